// ===== rtl/dstrb_pkg.sv =====
// Shared types and constants for the dual-source trace ring buffer.
// Used by the controller, the datapath and the top level; no dependencies.
package dstrb_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 11;

   typedef enum logic [2:0] {
      OP_ADD      = 3'd0,
      OP_READ_ALL = 3'd1,
      OP_READ_CPU = 3'd2,
      OP_READ_PPU = 3'd3,
      OP_CLEAR    = 3'd4
   } op_type;

   typedef enum logic [0:0] {
      CSR_DEPTH    = 1'b0,
      CSR_PPU_CODE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ADD,
      ST_RING,
      ST_LOAD
   } state_type;

   typedef enum logic [1:0] {
      RES_NONE,
      RES_INPUT,
      RES_MEM
   } res_sel_type;

   typedef struct packed {
      logic capture;
      logic read_old;
      logic commit;
      logic read_ring;
      logic read_store;
      logic store_from_ring;
      logic clear;
      logic load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   hit;
      logic   rsp_free;
   } status_type;

endpackage

// ===== rtl/dstrb_ctrl.sv =====
// Sequencing state machine for the trace ring buffer.
// Depends on dstrb_pkg; drives commands into dstrb_dp.
module dstrb_ctrl
   import dstrb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_LOAD;
            case (status.op)
               OP_ADD: begin
                  cmd.read_old = 1'b1;
                  state_in     = ST_ADD;
               end
               OP_READ_ALL: begin
                  cmd.read_store = status.hit;
               end
               OP_READ_CPU, OP_READ_PPU: begin
                  if (status.hit) begin
                     cmd.read_ring = 1'b1;
                     state_in      = ST_RING;
                  end
               end
               OP_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               default: begin
                  state_in = ST_LOAD;
               end
            endcase
         end
         ST_ADD: begin
            cmd.commit = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_RING: begin
            cmd.read_store      = 1'b1;
            cmd.store_from_ring = 1'b1;
            state_in            = ST_LOAD;
         end
         ST_LOAD: begin
            // hold until the output register is free
            if (status.rsp_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/dstrb_dp.sv =====
// Datapath: sample stores, index rings, cursors, counts, config and output register.
// Depends on dstrb_pkg; driven by commands from dstrb_ctrl.
module dstrb_dp
   import dstrb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic [2:0]             req_operation,
   input  logic [31:0]            req_frame_number,
   input  logic [31:0]            req_cycle_stamp,
   input  logic signed [7:0]      req_access_type,
   input  logic signed [7:0]      req_source_unit,
   input  logic signed [7:0]      req_target_unit,
   input  logic [15:0]            req_bus_address,
   input  logic [7:0]             req_bus_data,
   input  logic [9:0]             req_age,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_valid_res,
   output logic [9:0]             rsp_slot,
   output logic [31:0]            rsp_out_frame,
   output logic [31:0]            rsp_out_cycle,
   output logic signed [7:0]      rsp_out_type,
   output logic signed [7:0]      rsp_out_source,
   output logic signed [7:0]      rsp_out_target,
   output logic [15:0]            rsp_out_address,
   output logic [7:0]             rsp_out_data,
   output logic [10:0]            rsp_total_count,
   output logic [10:0]            rsp_cpu_count,
   output logic [10:0]            rsp_ppu_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = ((AW > 11) ? AW : 11) + 1;
   localparam int DEPTH_RESET = (DEPTH < 1024) ? DEPTH : 1024;

   function automatic logic [AW-1:0] step_back(logic [AW-1:0] cur, logic [9:0] a,
                                               logic [10:0] dep);
      logic [CW-1:0] d, c, r;
      d = CW'(a) + CW'(1);
      c = CW'(cur);
      if (c >= d) r = c - d;
      else        r = c + CW'(dep) - d;
      return r[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] bump(logic [AW-1:0] cur, logic [10:0] dep);
      logic [CW-1:0] n;
      n = CW'(cur) + CW'(1);
      return (n >= CW'(dep)) ? '0 : n[AW-1:0];
   endfunction

   // configuration
   logic [10:0]       depth_ff;
   logic signed [7:0] ppu_code_ff;
   logic [10:0]       depth_wr;

   always_comb begin
      depth_wr = csr_write_data;
      if (depth_wr == 11'd0) depth_wr = 11'd1;
      if (32'(depth_wr) > 32'(DEPTH)) depth_wr = 11'(DEPTH);
   end

   // captured request
   op_type            op_ff;
   logic [31:0]       frame_ff, cycle_ff;
   logic signed [7:0] type_ff, src_ff, tgt_ff;
   logic [15:0]       addr_ff;
   logic [7:0]        data_ff;
   logic [9:0]        age_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_operation);
         frame_ff <= req_frame_number;
         cycle_ff <= req_cycle_stamp;
         type_ff  <= req_access_type;
         src_ff   <= req_source_unit;
         tgt_ff   <= req_target_unit;
         addr_ff  <= req_bus_address;
         data_ff  <= req_bus_data;
         age_ff   <= req_age;
      end
   end

   // cursors and counts
   logic [AW-1:0] main_cur_ff, cpu_cur_ff, ppu_cur_ff;
   logic [10:0]   total_ff, cpu_ff, ppu_ff;

   logic [63:0]   stamp_mem [DEPTH];
   logic [47:0]   access_mem [DEPTH];
   logic [AW-1:0] cpu_ring [DEPTH];
   logic [AW-1:0] ppu_ring [DEPTH];
   logic [63:0]   stamp_q;
   logic [47:0]   access_q;
   logic [AW-1:0] cpu_ring_q, ppu_ring_q;

   logic          is_ppu, old_ppu, full;
   logic [11:0]   tot_n, cpu_n, ppu_n;
   logic [AW-1:0] store_addr, access_addr;

   assign is_ppu  = (src_ff == ppu_code_ff);
   assign old_ppu = ($signed(access_q[39:32]) == ppu_code_ff);
   assign full    = (total_ff >= depth_ff);

   always_comb begin
      tot_n = full ? {1'b0, total_ff} : {1'b0, total_ff} + 12'd1;
      ppu_n = {1'b0, ppu_ff} + {11'd0, is_ppu};
      cpu_n = {1'b0, cpu_ff} + {11'd0, !is_ppu};
      if (full) begin
         if (old_ppu) begin
            if (ppu_n != 12'd0) ppu_n = ppu_n - 12'd1;
         end else begin
            if (cpu_n != 12'd0) cpu_n = cpu_n - 12'd1;
         end
      end
      if (ppu_n > tot_n) ppu_n = tot_n;
      if (cpu_n > tot_n) cpu_n = tot_n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff    <= 11'(DEPTH_RESET);
         ppu_code_ff <= 8'sd1;
         main_cur_ff <= '0;
         cpu_cur_ff  <= '0;
         ppu_cur_ff  <= '0;
         total_ff    <= '0;
         cpu_ff      <= '0;
         ppu_ff      <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_DEPTH: begin
               depth_ff    <= depth_wr;
               main_cur_ff <= '0;
               cpu_cur_ff  <= '0;
               ppu_cur_ff  <= '0;
               total_ff    <= '0;
               cpu_ff      <= '0;
               ppu_ff      <= '0;
            end
            CSR_PPU_CODE: begin
               ppu_code_ff <= csr_write_data[7:0];
            end
            default: begin
               ppu_code_ff <= ppu_code_ff;
            end
         endcase
      end else if (cmd.clear) begin
         main_cur_ff <= '0;
         cpu_cur_ff  <= '0;
         ppu_cur_ff  <= '0;
         total_ff    <= '0;
         cpu_ff      <= '0;
         ppu_ff      <= '0;
      end else if (cmd.commit) begin
         main_cur_ff <= bump(main_cur_ff, depth_ff);
         if (is_ppu) ppu_cur_ff <= bump(ppu_cur_ff, depth_ff);
         else        cpu_cur_ff <= bump(cpu_cur_ff, depth_ff);
         total_ff <= tot_n[10:0];
         cpu_ff   <= cpu_n[10:0];
         ppu_ff   <= ppu_n[10:0];
      end
   end

   // memories
   assign store_addr  = cmd.store_from_ring ?
                        ((op_ff == OP_READ_PPU) ? ppu_ring_q : cpu_ring_q) :
                        step_back(main_cur_ff, age_ff, depth_ff);
   assign access_addr = cmd.read_old ? main_cur_ff : store_addr;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         stamp_mem[main_cur_ff]  <= {frame_ff, cycle_ff};
         access_mem[main_cur_ff] <= {type_ff, src_ff, tgt_ff, addr_ff, data_ff};
      end
      if (cmd.read_store) stamp_q <= stamp_mem[store_addr];
      if (cmd.read_store || cmd.read_old) access_q <= access_mem[access_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && is_ppu)  ppu_ring[ppu_cur_ff] <= main_cur_ff;
      if (cmd.commit && !is_ppu) cpu_ring[cpu_cur_ff] <= main_cur_ff;
      if (cmd.read_ring) begin
         cpu_ring_q <= cpu_ring[step_back(cpu_cur_ff, age_ff, depth_ff)];
         ppu_ring_q <= ppu_ring[step_back(ppu_cur_ff, age_ff, depth_ff)];
      end
   end

   // result selection
   res_sel_type   res_sel_ff;
   logic [AW-1:0] res_slot_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         res_sel_ff <= RES_NONE;
      end else if (cmd.commit) begin
         res_sel_ff  <= RES_INPUT;
         res_slot_ff <= main_cur_ff;
      end else if (cmd.read_store) begin
         res_sel_ff  <= RES_MEM;
         res_slot_ff <= store_addr;
      end
   end

   // status
   logic rsp_valid_ff;

   always_comb begin
      status.op       = op_ff;
      status.rsp_free = !rsp_valid_ff || !rsp_stall;
      case (op_ff)
         OP_READ_ALL: status.hit = ({1'b0, age_ff} < total_ff);
         OP_READ_CPU: status.hit = ({1'b0, age_ff} < cpu_ff);
         OP_READ_PPU: status.hit = ({1'b0, age_ff} < ppu_ff);
         default:     status.hit = 1'b0;
      endcase
   end

   // output register
   logic              res_ff;
   logic [9:0]        slot_ff;
   logic [31:0]       o_frame_ff, o_cycle_ff;
   logic signed [7:0] o_type_ff, o_src_ff, o_tgt_ff;
   logic [15:0]       o_addr_ff;
   logic [7:0]        o_data_ff;
   logic [10:0]       o_tot_ff, o_cpu_ff, o_ppu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         o_tot_ff <= total_ff;
         o_cpu_ff <= cpu_ff;
         o_ppu_ff <= ppu_ff;
         case (res_sel_ff)
            RES_INPUT: begin
               res_ff     <= 1'b1;
               slot_ff    <= 10'(res_slot_ff);
               o_frame_ff <= frame_ff;
               o_cycle_ff <= cycle_ff;
               o_type_ff  <= type_ff;
               o_src_ff   <= src_ff;
               o_tgt_ff   <= tgt_ff;
               o_addr_ff  <= addr_ff;
               o_data_ff  <= data_ff;
            end
            RES_MEM: begin
               res_ff     <= 1'b1;
               slot_ff    <= 10'(res_slot_ff);
               o_frame_ff <= stamp_q[63:32];
               o_cycle_ff <= stamp_q[31:0];
               o_type_ff  <= access_q[47:40];
               o_src_ff   <= access_q[39:32];
               o_tgt_ff   <= access_q[31:24];
               o_addr_ff  <= access_q[23:8];
               o_data_ff  <= access_q[7:0];
            end
            default: begin
               res_ff     <= 1'b0;
               slot_ff    <= '0;
               o_frame_ff <= '0;
               o_cycle_ff <= '0;
               o_type_ff  <= '0;
               o_src_ff   <= '0;
               o_tgt_ff   <= '0;
               o_addr_ff  <= '0;
               o_data_ff  <= '0;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_valid_res   = res_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_out_frame   = o_frame_ff;
   assign rsp_out_cycle   = o_cycle_ff;
   assign rsp_out_type    = o_type_ff;
   assign rsp_out_source  = o_src_ff;
   assign rsp_out_target  = o_tgt_ff;
   assign rsp_out_address = o_addr_ff;
   assign rsp_out_data    = o_data_ff;
   assign rsp_total_count = o_tot_ff;
   assign rsp_cpu_count   = o_cpu_ff;
   assign rsp_ppu_count   = o_ppu_ff;

endmodule

// ===== rtl/dual_source_trace_ring_buffer.sv =====
// Dual-source trace ring buffer, top level: dstrb_ctrl sequences dstrb_dp.
// Add reads the old sample, then commits; a CPU/PPU read hit reads the index ring, then the
// sample store; an overall read hit reads the sample store; clear and misses do no read. Each
// then waits in LOAD for a free output register. One item is worked on at a time; the next
// transfer is taken the cycle after the result is loaded.
// Reset (synchronous): cursors and counts zero, depth 1024 (or DEPTH if less).
module dual_source_trace_ring_buffer
   import dstrb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [2:0]             req_operation,
   input  logic [31:0]            req_frame_number,
   input  logic [31:0]            req_cycle_stamp,
   input  logic signed [7:0]      req_access_type,
   input  logic signed [7:0]      req_source_unit,
   input  logic signed [7:0]      req_target_unit,
   input  logic [15:0]            req_bus_address,
   input  logic [7:0]             req_bus_data,
   input  logic [9:0]             req_age,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_valid_res,
   output logic [9:0]             rsp_slot,
   output logic [31:0]            rsp_out_frame,
   output logic [31:0]            rsp_out_cycle,
   output logic signed [7:0]      rsp_out_type,
   output logic signed [7:0]      rsp_out_source,
   output logic signed [7:0]      rsp_out_target,
   output logic [15:0]            rsp_out_address,
   output logic [7:0]             rsp_out_data,
   output logic [10:0]            rsp_total_count,
   output logic [10:0]            rsp_cpu_count,
   output logic [10:0]            rsp_ppu_count
);

   cmd_type    cmd;
   status_type status;

   dstrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dstrb_dp #(.DEPTH(DEPTH)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_operation    (req_operation),
      .req_frame_number (req_frame_number),
      .req_cycle_stamp  (req_cycle_stamp),
      .req_access_type  (req_access_type),
      .req_source_unit  (req_source_unit),
      .req_target_unit  (req_target_unit),
      .req_bus_address  (req_bus_address),
      .req_bus_data     (req_bus_data),
      .req_age          (req_age),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_slot         (rsp_slot),
      .rsp_out_frame    (rsp_out_frame),
      .rsp_out_cycle    (rsp_out_cycle),
      .rsp_out_type     (rsp_out_type),
      .rsp_out_source   (rsp_out_source),
      .rsp_out_target   (rsp_out_target),
      .rsp_out_address  (rsp_out_address),
      .rsp_out_data     (rsp_out_data),
      .rsp_total_count  (rsp_total_count),
      .rsp_cpu_count    (rsp_cpu_count),
      .rsp_ppu_count    (rsp_ppu_count)
   );

endmodule

// ===== rtl/dstrb_checker.sv =====
// Port-level checks for the trace ring buffer, bound to the top level.
// Depends only on the top level's ports.
module dstrb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_valid_res,
   input logic [9:0]  rsp_slot,
   input logic [31:0] rsp_out_frame,
   input logic [10:0] rsp_total_count,
   input logic [10:0] rsp_cpu_count,
   input logic [10:0] rsp_ppu_count
);

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cpu_count <= rsp_total_count) &&
                    (rsp_ppu_count <= rsp_total_count))
      else $error("source count above total count");

   a_hit_needs_sample: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_valid_res) |-> (rsp_total_count != 11'd0))
      else $error("valid sample reported from an empty store");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_slot == 10'd0) && (rsp_out_frame == 32'd0))
      else $error("miss result carries sample data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_total_count))
      else $error("stalled result changed");

endmodule

bind dual_source_trace_ring_buffer dstrb_checker u_dstrb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_valid_res   (rsp_valid_res),
   .rsp_slot        (rsp_slot),
   .rsp_out_frame   (rsp_out_frame),
   .rsp_total_count (rsp_total_count),
   .rsp_cpu_count   (rsp_cpu_count),
   .rsp_ppu_count   (rsp_ppu_count)
);
